[rtl/eibr_pkg.sv]
// Shared types and constants for the edge-interval biphase receiver.
`default_nettype none

package eibr_pkg;

   // Capture timestamp width and derived widths
   localparam int TIME_BITS = 16;
   localparam int WRAP_BITS = TIME_BITS + 1;
   localparam int DIFF_BITS = TIME_BITS + 2;
   localparam int SUM_BITS  = 9;

   // Register map (index = paddr[4:2])
   localparam logic [2:0] REG_CAPTURE_WRAP    = 3'd0;
   localparam logic [2:0] REG_SHORT_LOW       = 3'd1;
   localparam logic [2:0] REG_SHORT_HIGH      = 3'd2;
   localparam logic [2:0] REG_LONG_LOW        = 3'd3;
   localparam logic [2:0] REG_LONG_HIGH       = 3'd4;
   localparam logic [2:0] REG_PILOT_NEEDED    = 3'd5;
   localparam logic [2:0] REG_FRAME_HALF_BITS = 3'd6;

   // Register reset values
   localparam logic [WRAP_BITS-1:0] RST_CAPTURE_WRAP    = 17'd65536;
   localparam logic [15:0]          RST_SHORT_LOW       = 16'd200;
   localparam logic [15:0]          RST_SHORT_HIGH      = 16'd320;
   localparam logic [15:0]          RST_LONG_LOW        = 16'd440;
   localparam logic [15:0]          RST_LONG_HIGH       = 16'd580;
   localparam logic [7:0]           RST_PILOT_NEEDED    = 8'd8;
   localparam logic [7:0]           RST_FRAME_HALF_BITS = 8'd128;

   // Interval class; the numeric value is the half-bit weight
   typedef enum logic [1:0] {
      CLS_INVALID = 2'd0,
      CLS_SHORT   = 2'd1,
      CLS_LONG    = 2'd2
   } class_type;

   // Receiver mode
   typedef enum logic [1:0] {
      MODE_WARMUP = 2'b01,
      MODE_FRAME  = 2'b10
   } mode_type;

endpackage

`default_nettype wire

[rtl/edge_interval_biphase_receiver.sv]
// Top level: edge-interval classifier, pilot search and pairwise biphase decoder.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | req_capture_time
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_bit_value, rsp_bit_valid,
//           |           |                      | rsp_bit_index, rsp_frame_done
//   csr     | in/out    | psel/penable/pready  | paddr, pwdata, prdata
//
// One word per cycle unless rsp_stall holds a full result register: an edge timestamp is
// registered in the input register, then classification, pilot tracking and decoding run
// combinationally into the result register, raising rsp_valid; edges that give no result
// only update state. Reset is synchronous and restores registers and receiver state.
// req_stall rises only while the result register is full and rsp_stall is high.
`default_nettype none

module edge_interval_biphase_receiver #(
   parameter int COUNT_BITS = 8
) (
   input  wire                                clock,
   input  wire                                reset,
   // Edge timestamps
   input  wire                                req_valid,
   output logic                               req_stall,
   input  wire [eibr_pkg::TIME_BITS-1:0]      req_capture_time,
   // Decoded bits
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output logic                               rsp_bit_value,
   output logic                               rsp_bit_valid,
   output logic [7:0]                         rsp_bit_index,
   output logic                               rsp_frame_done,
   // Register port
   input  wire                                psel,
   input  wire                                penable,
   input  wire                                pwrite,
   input  wire [4:0]                          paddr,
   input  wire [31:0]                         pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);
   import eibr_pkg::*;

   localparam int CMP_W = (COUNT_BITS > 8) ? COUNT_BITS : 8;

   // Configuration registers
   logic [WRAP_BITS-1:0] wrap_ff;
   logic [15:0]          short_low_ff, short_high_ff, long_low_ff, long_high_ff;
   logic [7:0]           pilot_needed_ff, frame_half_bits_ff;

   // Input register
   logic                 in_valid_ff, in_valid_in;
   logic [TIME_BITS-1:0] in_time_ff;

   // Receiver state
   mode_type             mode_ff, mode_in;
   logic                 have_first_ff, have_first_in;
   logic [TIME_BITS-1:0] prev_time_ff, prev_time_in;
   logic                 long_seen_ff, long_seen_in;
   logic [COUNT_BITS-1:0] pilot_run_ff, pilot_run_in;
   logic [SUM_BITS-1:0]  half_sum_ff, half_sum_in;
   logic                 dec_locked_ff, dec_locked_in;
   logic                 dec_pending_ff, dec_pending_in;
   class_type            dec_prev_class_ff, dec_prev_class_in;
   logic                 dec_prev_bit_ff, dec_prev_bit_in;
   logic [COUNT_BITS-1:0] bit_count_ff, bit_count_in;

   // Result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_bit_value_ff, rsp_bit_valid_ff, rsp_frame_done_ff;
   logic [7:0]           rsp_bit_index_ff;

   // Step datapath
   logic                 advance;
   class_type            cls;
   logic [DIFF_BITS-1:0] wrapped_sum, diff;
   logic                 wrap_bad;
   logic [COUNT_BITS-1:0] pilot_sat;
   logic [SUM_BITS-1:0]  sum_next;
   logic                 got_bit, dec_bit, has_result, done;
   logic [CMP_W-1:0]     count_ext;
   logic [7:0]           index_sat;

   //--------------------------------------------------------------------------
   // Register port
   //--------------------------------------------------------------------------
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_ff            <= RST_CAPTURE_WRAP;
         short_low_ff       <= RST_SHORT_LOW;
         short_high_ff      <= RST_SHORT_HIGH;
         long_low_ff        <= RST_LONG_LOW;
         long_high_ff       <= RST_LONG_HIGH;
         pilot_needed_ff    <= RST_PILOT_NEEDED;
         frame_half_bits_ff <= RST_FRAME_HALF_BITS;
      end else if (psel && penable && pwrite) begin
         case (paddr[4:2])
            REG_CAPTURE_WRAP:    wrap_ff            <= pwdata[WRAP_BITS-1:0];
            REG_SHORT_LOW:       short_low_ff       <= pwdata[15:0];
            REG_SHORT_HIGH:      short_high_ff      <= pwdata[15:0];
            REG_LONG_LOW:        long_low_ff        <= pwdata[15:0];
            REG_LONG_HIGH:       long_high_ff       <= pwdata[15:0];
            REG_PILOT_NEEDED:    pilot_needed_ff    <= pwdata[7:0];
            REG_FRAME_HALF_BITS: frame_half_bits_ff <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   // Read back
   always_comb begin
      case (paddr[4:2])
         REG_CAPTURE_WRAP:    prdata = 32'(wrap_ff);
         REG_SHORT_LOW:       prdata = 32'(short_low_ff);
         REG_SHORT_HIGH:      prdata = 32'(short_high_ff);
         REG_LONG_LOW:        prdata = 32'(long_low_ff);
         REG_LONG_HIGH:       prdata = 32'(long_high_ff);
         REG_PILOT_NEEDED:    prdata = 32'(pilot_needed_ff);
         REG_FRAME_HALF_BITS: prdata = 32'(frame_half_bits_ff);
         default:             prdata = 32'd0;
      endcase
   end

   //--------------------------------------------------------------------------
   // Handshake: advance the input word when the result register can take it
   //--------------------------------------------------------------------------
   assign advance     = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall   = in_valid_ff && !advance;
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_time_ff <= req_capture_time;
      end
   end

   //--------------------------------------------------------------------------
   // Interval class: wrapped difference against the two windows, short first
   //--------------------------------------------------------------------------
   assign wrapped_sum = DIFF_BITS'(wrap_ff) + DIFF_BITS'(in_time_ff);
   assign wrap_bad    = (in_time_ff < prev_time_ff) &&
                        (wrapped_sum < DIFF_BITS'(prev_time_ff));
   assign diff        = (in_time_ff < prev_time_ff)
                        ? (wrapped_sum - DIFF_BITS'(prev_time_ff))
                        : DIFF_BITS'(in_time_ff - prev_time_ff);

   always_comb begin
      if (wrap_bad) begin
         cls = CLS_INVALID;
      end else if (diff > DIFF_BITS'(short_low_ff) && diff < DIFF_BITS'(short_high_ff)) begin
         cls = CLS_SHORT;
      end else if (diff > DIFF_BITS'(long_low_ff) && diff < DIFF_BITS'(long_high_ff)) begin
         cls = CLS_LONG;
      end else begin
         cls = CLS_INVALID;
      end
   end

   // Saturating pilot count and bit index; plain half-bit sum
   assign pilot_sat = (pilot_run_ff == {COUNT_BITS{1'b1}}) ? pilot_run_ff
                                                           : pilot_run_ff + 1'b1;
   assign sum_next  = half_sum_ff + SUM_BITS'(cls);
   assign count_ext = CMP_W'(bit_count_ff);
   assign index_sat = (count_ext > CMP_W'(255)) ? 8'hFF : count_ext[7:0];

   //--------------------------------------------------------------------------
   // Step: warm-up pilot search, frame decode, frame end
   //--------------------------------------------------------------------------
   always_comb begin
      mode_in           = mode_ff;
      have_first_in     = have_first_ff;
      prev_time_in      = prev_time_ff;
      long_seen_in      = long_seen_ff;
      pilot_run_in      = pilot_run_ff;
      half_sum_in       = half_sum_ff;
      dec_locked_in     = dec_locked_ff;
      dec_pending_in    = dec_pending_ff;
      dec_prev_class_in = dec_prev_class_ff;
      dec_prev_bit_in   = dec_prev_bit_ff;
      bit_count_in      = bit_count_ff;
      got_bit           = 1'b0;
      dec_bit           = 1'b0;
      done              = 1'b0;
      has_result        = 1'b0;

      if (!have_first_ff) begin
         // First edge only latches its time
         prev_time_in  = in_time_ff;
         have_first_in = 1'b1;
      end else if (mode_ff == MODE_WARMUP) begin
         prev_time_in = in_time_ff;
         if (!long_seen_ff) begin
            if (cls == CLS_LONG) begin
               long_seen_in = 1'b1;
            end
         end else if (cls == CLS_SHORT) begin
            if (CMP_W'(pilot_sat) >= CMP_W'(pilot_needed_ff)) begin
               // Pilot complete: enter frame with a fresh decoder
               long_seen_in      = 1'b0;
               pilot_run_in      = '0;
               mode_in           = MODE_FRAME;
               half_sum_in       = '0;
               bit_count_in      = '0;
               dec_locked_in     = 1'b0;
               dec_pending_in    = 1'b0;
               dec_prev_class_in = CLS_INVALID;
               dec_prev_bit_in   = 1'b0;
            end else begin
               pilot_run_in = pilot_sat;
            end
         end else begin
            pilot_run_in = '0;
         end
      end else if (cls == CLS_INVALID) begin
         // Invalid interval in frame: drop back to reset state
         mode_in           = MODE_WARMUP;
         have_first_in     = 1'b0;
         prev_time_in      = '0;
         long_seen_in      = 1'b0;
         pilot_run_in      = '0;
         half_sum_in       = '0;
         dec_locked_in     = 1'b0;
         dec_pending_in    = 1'b0;
         dec_prev_class_in = CLS_INVALID;
         dec_prev_bit_in   = 1'b0;
         bit_count_in      = '0;
      end else begin
         prev_time_in = in_time_ff;
         half_sum_in  = sum_next;

         // Pairwise decoder
         if (!dec_locked_ff) begin
            if (cls == CLS_SHORT) begin
               dec_pending_in = 1'b0;
            end else begin
               dec_pending_in    = 1'b1;
               dec_prev_class_in = CLS_LONG;
            end
            dec_locked_in   = 1'b1;
            dec_prev_bit_in = 1'b1;
         end else if (!dec_pending_ff) begin
            dec_prev_class_in = cls;
            dec_pending_in    = 1'b1;
         end else begin
            got_bit        = 1'b1;
            dec_pending_in = 1'b0;
            if (dec_prev_class_ff != cls) begin
               if (dec_prev_class_ff == CLS_SHORT && cls == CLS_LONG) begin
                  dec_bit           = dec_prev_bit_ff;
                  dec_prev_class_in = CLS_LONG;
                  dec_pending_in    = 1'b1;
               end else if (dec_prev_class_ff == CLS_LONG && cls == CLS_SHORT) begin
                  dec_bit         = !dec_prev_bit_ff;
                  dec_prev_bit_in = !dec_prev_bit_ff;
               end
            end else if (dec_prev_class_ff == CLS_SHORT) begin
               dec_bit = dec_prev_bit_ff;
            end else if (dec_prev_class_ff == CLS_LONG) begin
               dec_bit         = !dec_prev_bit_ff;
               dec_prev_bit_in = !dec_prev_bit_ff;
               dec_pending_in  = 1'b1;
            end
         end

         if (got_bit && bit_count_ff != {COUNT_BITS{1'b1}}) begin
            bit_count_in = bit_count_ff + 1'b1;
         end
         has_result = got_bit;

         // Frame end: flag it and return to reset state
         if (sum_next >= SUM_BITS'(frame_half_bits_ff)) begin
            done              = 1'b1;
            has_result        = 1'b1;
            mode_in           = MODE_WARMUP;
            have_first_in     = 1'b0;
            prev_time_in      = '0;
            long_seen_in      = 1'b0;
            pilot_run_in      = '0;
            half_sum_in       = '0;
            dec_locked_in     = 1'b0;
            dec_pending_in    = 1'b0;
            dec_prev_class_in = CLS_INVALID;
            dec_prev_bit_in   = 1'b0;
            bit_count_in      = '0;
         end
      end
   end

   // Hold state; advance it with each word
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff           <= MODE_WARMUP;
         have_first_ff     <= 1'b0;
         prev_time_ff      <= '0;
         long_seen_ff      <= 1'b0;
         pilot_run_ff      <= '0;
         half_sum_ff       <= '0;
         dec_locked_ff     <= 1'b0;
         dec_pending_ff    <= 1'b0;
         dec_prev_class_ff <= CLS_INVALID;
         dec_prev_bit_ff   <= 1'b0;
         bit_count_ff      <= '0;
      end else if (advance) begin
         mode_ff           <= mode_in;
         have_first_ff     <= have_first_in;
         prev_time_ff      <= prev_time_in;
         long_seen_ff      <= long_seen_in;
         pilot_run_ff      <= pilot_run_in;
         half_sum_ff       <= half_sum_in;
         dec_locked_ff     <= dec_locked_in;
         dec_pending_ff    <= dec_pending_in;
         dec_prev_class_ff <= dec_prev_class_in;
         dec_prev_bit_ff   <= dec_prev_bit_in;
         bit_count_ff      <= bit_count_in;
      end
   end

   //--------------------------------------------------------------------------
   // Result register
   //--------------------------------------------------------------------------
   assign rsp_valid_in = (advance && has_result) ? 1'b1
                       : (rsp_stall ? rsp_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && has_result) begin
         rsp_bit_value_ff  <= got_bit && dec_bit;
         rsp_bit_valid_ff  <= got_bit;
         rsp_bit_index_ff  <= got_bit ? index_sat : 8'd0;
         rsp_frame_done_ff <= done;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_bit_value  = rsp_bit_value_ff;
   assign rsp_bit_valid  = rsp_bit_valid_ff;
   assign rsp_bit_index  = rsp_bit_index_ff;
   assign rsp_frame_done = rsp_frame_done_ff;

   //--------------------------------------------------------------------------
   // Checks
   //--------------------------------------------------------------------------
   a_frame_has_first_edge: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_FRAME |-> have_first_ff)
      else $error("frame mode without a latched first edge");

   a_frame_pilot_cleared: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_FRAME |-> (!long_seen_ff && pilot_run_ff == '0))
      else $error("pilot tracking not cleared in frame mode");

   a_result_from_advance: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff ##1 rsp_valid_ff |-> $past(advance))
      else $error("result appeared without an advancing word");

   a_warmup_no_decoder: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_WARMUP |-> (!dec_locked_ff && !dec_pending_ff && half_sum_ff == '0))
      else $error("decoder state active during warm-up");

endmodule

`default_nettype wire

[tb/tb.sv]
// Testbench for the edge-interval biphase receiver: stimulus, bit prediction and checks.
`timescale 1ns / 1ps

module tb;
   import eibr_pkg::*;

   // Predicts decoded bits from edge timestamps and checks the received words
   class biphase_scoreboard;
      typedef struct packed {
         logic       value;
         logic       valid;
         logic [7:0] index;
         logic       done;
      } bit_word;

      // Register copies
      logic [16:0] wrap_period;
      logic [15:0] short_lo;
      logic [15:0] short_hi;
      logic [15:0] long_lo;
      logic [15:0] long_hi;
      logic [7:0]  pilot_needed;
      logic [7:0]  frame_half_bits;

      // Receiver state
      mode_type    mode;
      logic        first_seen;
      logic        long_found;
      logic [15:0] prev_stamp;
      logic [7:0]  pilot_count;
      logic [8:0]  half_sum;
      logic        locked;
      logic        pending;
      logic [1:0]  pair_class;
      logic        last_bit;
      logic [7:0]  bit_pos;

      bit_word expected_bits[$];
      int      errors;
      int      bits_checked;
      int      frames_done;

      function new();
         wrap_period     = RST_CAPTURE_WRAP;
         short_lo        = RST_SHORT_LOW;
         short_hi        = RST_SHORT_HIGH;
         long_lo         = RST_LONG_LOW;
         long_hi         = RST_LONG_HIGH;
         pilot_needed    = RST_PILOT_NEEDED;
         frame_half_bits = RST_FRAME_HALF_BITS;
         errors          = 0;
         bits_checked    = 0;
         frames_done     = 0;
         clear_receiver();
      endfunction

      function void clear_receiver();
         mode        = MODE_WARMUP;
         first_seen  = 1'b0;
         long_found  = 1'b0;
         prev_stamp  = '0;
         pilot_count = '0;
         half_sum    = '0;
         locked      = 1'b0;
         pending     = 1'b0;
         pair_class  = '0;
         last_bit    = 1'b0;
         bit_pos     = '0;
      endfunction

      // Store a register write, truncated to the register width
      function void apply_reg(logic [2:0] idx, logic [31:0] value);
         case (idx)
            REG_CAPTURE_WRAP:    wrap_period     = value[16:0];
            REG_SHORT_LOW:       short_lo        = value[15:0];
            REG_SHORT_HIGH:      short_hi        = value[15:0];
            REG_LONG_LOW:        long_lo         = value[15:0];
            REG_LONG_HIGH:       long_hi         = value[15:0];
            REG_PILOT_NEEDED:    pilot_needed    = value[7:0];
            REG_FRAME_HALF_BITS: frame_half_bits = value[7:0];
            default: ;
         endcase
      endfunction

      function logic [31:0] reg_value(logic [2:0] idx);
         case (idx)
            REG_CAPTURE_WRAP:    return 32'(wrap_period);
            REG_SHORT_LOW:       return 32'(short_lo);
            REG_SHORT_HIGH:      return 32'(short_hi);
            REG_LONG_LOW:        return 32'(long_lo);
            REG_LONG_HIGH:       return 32'(long_hi);
            REG_PILOT_NEEDED:    return 32'(pilot_needed);
            REG_FRAME_HALF_BITS: return 32'(frame_half_bits);
            default:             return 32'd0;
         endcase
      endfunction

      // Class the interval since the previous edge, allowing one counter wrap
      function class_type class_of(logic [15:0] now_s);
         int unsigned w;
         int unsigned n;
         int unsigned p;
         int unsigned span;
         w = wrap_period;
         n = now_s;
         p = prev_stamp;
         if (n < p) begin
            if (w + n < p) return CLS_INVALID;
            span = w + n - p;
         end else begin
            span = n - p;
         end
         // short window wins where the two overlap
         if (span > short_lo && span < short_hi) return CLS_SHORT;
         if (span > long_lo && span < long_hi) return CLS_LONG;
         return CLS_INVALID;
      endfunction

      // Pairwise biphase decode; returns 1 when a bit comes out
      function bit pair_decode(class_type c, output logic b);
         b = 1'b0;
         if (!locked) begin
            if (c == CLS_SHORT) begin
               pending = 1'b0;
            end else if (c == CLS_LONG) begin
               pending    = 1'b1;
               pair_class = CLS_LONG;
            end
            locked   = 1'b1;
            last_bit = 1'b1;
            return 1'b0;
         end
         if (!pending) begin
            pair_class = c;
            pending    = 1'b1;
            return 1'b0;
         end
         pending = 1'b0;
         if (pair_class != c) begin
            if (pair_class == CLS_SHORT && c == CLS_LONG) begin
               b          = last_bit;
               pair_class = CLS_LONG;
               pending    = 1'b1;
            end else if (pair_class == CLS_LONG && c == CLS_SHORT) begin
               b        = ~last_bit;
               last_bit = b;
            end
            // any other pair gives a 0 bit and keeps the last bit
         end else if (pair_class == CLS_SHORT) begin
            b = last_bit;
         end else if (pair_class == CLS_LONG) begin
            b        = ~last_bit;
            last_bit = b;
            pending  = 1'b1;
         end
         return 1'b1;
      endfunction

      // Advance the receiver by one accepted edge and queue its result word
      function void predict_edge(logic [15:0] now_s);
         class_type c;
         logic      b;
         bit        got;
         bit_word   w;
         if (!first_seen) begin
            prev_stamp = now_s;
            first_seen = 1'b1;
            return;
         end
         c = class_of(now_s);
         if (mode == MODE_WARMUP) begin
            prev_stamp = now_s;
            if (!long_found) begin
               if (c == CLS_LONG) long_found = 1'b1;
            end else if (c == CLS_SHORT) begin
               if (pilot_count != 8'hFF) pilot_count++;
               if (pilot_count >= pilot_needed) begin
                  clear_receiver();
                  first_seen = 1'b1;
                  prev_stamp = now_s;
                  mode       = MODE_FRAME;
               end
            end else begin
               pilot_count = '0;
            end
            return;
         end
         // invalid interval inside a frame drops everything
         if (c == CLS_INVALID) begin
            clear_receiver();
            return;
         end
         prev_stamp = now_s;
         half_sum   = half_sum + {7'd0, c};
         got        = pair_decode(c, b);
         w.value    = got ? b : 1'b0;
         w.valid    = got;
         w.index    = got ? bit_pos : 8'd0;
         w.done     = 1'b0;
         if (got && bit_pos != 8'hFF) bit_pos++;
         if (half_sum >= {1'b0, frame_half_bits}) begin
            w.done = 1'b1;
            frames_done++;
            clear_receiver();
         end
         if (got || w.done) expected_bits.push_back(w);
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] seen);
         if (seen !== want) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, seen);
            errors++;
         end
      endfunction

      // Match one received word against the oldest prediction
      function void check_bit(logic value, logic valid, logic [7:0] index, logic done);
         bit_word w;
         if (expected_bits.size() == 0) begin
            $display("%0t: unexpected word, expected none actual value=%0d valid=%0d index=%0d done=%0d",
                     $time, value, valid, index, done);
            errors++;
            return;
         end
         w = expected_bits.pop_front();
         bits_checked++;
         compare_field("bit_value", 8'(w.value), 8'(value));
         compare_field("bit_valid", 8'(w.valid), 8'(valid));
         compare_field("bit_index", w.index, index);
         compare_field("frame_done", 8'(w.done), 8'(done));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic [15:0] req_capture_time = '0;
   logic        rsp_stall = 1'b0;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   wire         req_stall;
   wire         rsp_valid;
   wire         rsp_bit_value;
   wire         rsp_bit_valid;
   wire  [7:0]  rsp_bit_index;
   wire         rsp_frame_done;
   wire  [31:0] prdata;
   wire         pready;

   biphase_scoreboard sb;
   bit          jitter_on = 1'b1;
   int          stall_left = 0;
   int          edges_sent = 0;
   int unsigned gen_stamp;
   int unsigned gen_mod;

   // Register settings per random phase: wrap, short lo/hi, long lo/hi, pilot, frame
   int unsigned phase_regs [6][7] = '{
      '{65536, 200,   320, 440, 580,   8, 128},
      '{ 1000,  10,    30,  40,  70,   1,   2},
      '{65536,   0, 65535, 100, 200, 255, 255},
      '{40000,  50,    90,  60, 200,   0, 255},
      '{    1, 100,   150, 200, 300,   3,  20},
      '{30000, 100,   150, 200, 300,   3,  20}
   };
   int unsigned phase_budget [6] = '{260, 200, 50, 150, 80, 220};
   bit          phase_jitter [6] = '{1, 0, 1, 1, 1, 0};

   // Mix of boundaries, wraps, pilot breaks, frame ends and an invalid in-frame interval
   logic [15:0] directed_stamps [25] = '{
      16'd65535, 16'd499, 16'd749, 16'd1069, 16'd1270, 16'd1589, 16'd2089,
      16'd2339, 16'd2780, 16'd3359, 16'd0, 16'd500, 16'd750, 16'd1000,
      16'd1250, 16'd1500, 16'd1750, 16'd1950, 16'd100, 16'd600, 16'd850,
      16'd1100, 16'd1350, 16'd1600, 16'd2100
   };

   edge_interval_biphase_receiver dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_capture_time (req_capture_time),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_bit_value    (rsp_bit_value),
      .rsp_bit_valid    (rsp_bit_valid),
      .rsp_bit_index    (rsp_bit_index),
      .rsp_frame_done   (rsp_frame_done),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always #5 clock = ~clock;

   // Check each accepted result word, then pick the stall for the next cycle
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_bit(rsp_bit_value, rsp_bit_valid, rsp_bit_index, rsp_frame_done);
      if (jitter_on && stall_left == 0 && $urandom_range(0, 5) == 0)
         stall_left = $urandom_range(1, 7);
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Hard stop if the run hangs
   initial begin
      #2000000;
      $display("FAILED: results differ");
      $finish;
   end

   task write_reg(input logic [2:0] idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      sb.apply_reg(idx, value);
      @(posedge clock);
   endtask

   // Read a register back and compare with the predicted copy
   task expect_reg(input logic [2:0] idx);
      logic [31:0] seen;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      seen = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (seen !== sb.reg_value(idx)) begin
         $display("%0t: register %0d mismatch, expected %0d actual %0d",
                  $time, idx, sb.reg_value(idx), seen);
         sb.errors++;
      end
      @(posedge clock);
   endtask

   // Offer one timestamp word, with an optional idle burst first
   task send_edge(input logic [15:0] stamp);
      if (jitter_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_capture_time <= stamp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.predict_edge(stamp);
      edges_sent++;
   endtask

   // Drop valid and wait until every predicted word has come back
   task drain();
      req_valid <= 1'b0;
      while (sb.expected_bits.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function int unsigned pick_between(int unsigned lo, int unsigned hi);
      if (hi > lo + 1) return $urandom_range(lo + 1, hi - 1);
      return $urandom_range(0, 2000);
   endfunction

   // Interval of the wanted class, now and then a random one
   function int unsigned pick_interval(class_type want);
      if ($urandom_range(0, 99) < 4) return $urandom_range(0, 1200);
      if (want == CLS_SHORT) return pick_between(sb.short_lo, sb.short_hi);
      return pick_between(sb.long_lo, sb.long_hi);
   endfunction

   task hop(input int unsigned span);
      gen_stamp = (gen_stamp + span) % gen_mod;
      send_edge(gen_stamp[15:0]);
   endtask

   // Well-formed edge train: first edge, long, pilot, then frame half-bits
   task send_frame_train();
      int unsigned n;
      gen_mod   = (sb.wrap_period == 0) ? 1 : int'(sb.wrap_period);
      if (gen_mod > 65536) gen_mod = 65536;
      gen_stamp = $urandom_range(0, gen_mod - 1);
      send_edge(gen_stamp[15:0]);
      if ($urandom_range(0, 3) == 0) hop(pick_interval(CLS_SHORT));
      hop(pick_interval(CLS_LONG));
      repeat (int'(sb.pilot_needed) + $urandom_range(0, 1)) hop(pick_interval(CLS_SHORT));
      n = sb.frame_half_bits * 2 / 3 + $urandom_range(0, 6);
      repeat (n) hop(pick_interval($urandom_range(0, 1) ? CLS_SHORT : CLS_LONG));
   endtask

   initial begin
      int start_count;
      int k;
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset values, then a short frame setting for the directed words
      for (int r = REG_CAPTURE_WRAP; r <= REG_FRAME_HALF_BITS; r++) expect_reg(3'(r));
      write_reg(REG_PILOT_NEEDED, 32'd2);
      write_reg(REG_FRAME_HALF_BITS, 32'd7);
      foreach (directed_stamps[i]) send_edge(directed_stamps[i]);
      drain();

      // Random phases over several register settings
      for (int p = 0; p < 6; p++) begin
         jitter_on = phase_jitter[p];
         for (int r = REG_CAPTURE_WRAP; r <= REG_FRAME_HALF_BITS; r++) begin
            write_reg(3'(r), phase_regs[p][r]);
            expect_reg(3'(r));
         end
         start_count = edges_sent;
         while (edges_sent - start_count < phase_budget[p]) begin
            if ($urandom_range(0, 99) < 15)
               repeat ($urandom_range(1, 5)) send_edge(16'($urandom_range(0, 65535)));
            else
               send_frame_train();
         end
         drain();
      end

      // Let stragglers arrive, bounded
      k = 0;
      while (sb.expected_bits.size() != 0 && k < 2000) begin
         @(posedge clock);
         k++;
      end
      repeat (8) @(posedge clock);
      if (sb.expected_bits.size() != 0) begin
         $display("%0t: %0d predicted words never arrived", $time, sb.expected_bits.size());
         sb.errors++;
      end

      $display("Sent %0d edge timestamps across 7 register settings with random idling.",
               edges_sent);
      $display("Checked %0d result words, %0d of them closing a frame.",
               sb.bits_checked, sb.frames_done);
      if (sb.errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
